// ===== sv/bsr_pkg.sv =====
// ----------------------------------------------------------------------------
// bsr_pkg
// Shared types and constants of the byte stream reassembler.
// ----------------------------------------------------------------------------
package bsr_pkg;

    // widths fixed by the stream format
    localparam int POS_W  = 32;
    localparam int BYTE_W = 8;
    localparam int WIN_W  = 7;
    localparam int CNT_W  = 7;

    // default ring size
    localparam int CAPACITY_DEF = 64;

    // register file
    localparam int                ADDR_W      = 3;
    localparam int                DATA_W      = 32;
    localparam logic [0:0]        REG_WINDOW  = 1'b0;
    localparam logic [WIN_W-1:0]  WINDOW_RST  = 7'd64;

    // control sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_SCAN,
        ST_READ,
        ST_SEND,
        ST_STATUS
    } bsr_state_t;

endpackage

// ===== sv/bsr_ram.sv =====
// ----------------------------------------------------------------------------
// bsr_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module bsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge clk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/byte_stream_reassembler.sv =====
// ----------------------------------------------------------------------------
// byte_stream_reassembler
// Puts out-of-order stream bytes back in order through a ring of byte slots.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one request per byte (or bare end marker) with its absolute
//   32-bit stream position. m_* channel: one result per delivered in-order
//   byte, the final one flagged by m_last_of_run, or a single status result
//   when nothing is delivered. Every result carries the finished flag and
//   the pending byte count as they stand after the request.
//   The APB port holds the acceptance window at address 0.
// Sequence:
//   A request first computes and stores its byte (ST_CALC); unless the stream
//   has already finished, the valid flags of the contiguous run are then walked
//   one slot per cycle (ST_SCAN), and each byte is then read from the slot RAM
//   (ST_READ) and sent (ST_SEND), where a stalled receiver holds it. s_ready
//   is high only while the sequencer is idle; the last result may still wait
//   in the output register then.
// Reset: all slot flags cleared at once, positions and counters zeroed,
//   window set to 64. A stalled receiver holds the output register and the
//   sequencer waits; nothing is lost.
// ----------------------------------------------------------------------------
module byte_stream_reassembler
    import bsr_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    // request channel
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [POS_W-1:0]  s_byte_position,
    input  logic [BYTE_W-1:0] s_byte_value,
    input  logic              s_carries_byte,
    input  logic              s_ends_stream,
    // result channel
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_has_output_byte,
    output logic [BYTE_W-1:0] m_out_byte,
    output logic              m_last_of_run,
    output logic              m_stream_finished,
    output logic [CNT_W-1:0]  m_pending_count,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int               IDX_W    = $clog2(CAPACITY);
    localparam logic [IDX_W:0]   CAP_SUM  = (IDX_W+1)'(CAPACITY);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);

    // sequencer and stream state
    bsr_state_t          state_reg, state_next;
    logic [POS_W-1:0]    next_exp_reg, next_exp_next;
    logic [POS_W-1:0]    end_dist_reg, end_dist_next;
    logic                end_known_reg, end_known_next;
    logic                finished_reg, finished_next;
    logic [CNT_W-1:0]    stored_reg, stored_next;
    logic [IDX_W-1:0]    head_reg, head_next;
    logic [CAPACITY-1:0] valid_reg, valid_next;
    logic [WIN_W-1:0]    win_reg, win_next;
    logic [IDX_W-1:0]    ptr_reg, ptr_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [CNT_W-1:0]    remain_reg, remain_next;
    logic                fin_res_reg, fin_res_next;
    logic [CNT_W-1:0]    pend_res_reg, pend_res_next;
    logic                m_valid_reg, m_valid_next;

    // captured request and output payload
    logic [POS_W-1:0]    pos_reg;
    logic [POS_W-1:0]    seg_end_reg;
    logic [BYTE_W-1:0]   val_reg;
    logic                carries_reg;
    logic                eos_reg;
    logic                out_has_reg, out_has_next;
    logic [BYTE_W-1:0]   out_byte_reg, out_byte_next;
    logic                out_last_reg, out_last_next;
    logic                out_fin_reg, out_fin_next;
    logic [CNT_W-1:0]    out_pend_reg, out_pend_next;
    logic                out_load;

    // request evaluation
    logic [POS_W-1:0]    off;
    logic [POS_W-1:0]    eoff;
    logic [WIN_W-1:0]    lim;
    logic                in_win;
    logic                take_byte;
    logic                end_ok;
    logic [IDX_W:0]      slot_sum;
    logic [IDX_W-1:0]    slot;
    logic                scan_stop;
    logic                fin_now;
    logic                out_free;
    logic                in_accept;
    logic                cfg_we;

    // slot RAM ports
    logic                ram_we;
    logic                ram_re;
    logic [BYTE_W-1:0]   ram_rdata;

    assign in_accept = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_we    = psel && penable && pwrite;
    assign pready    = 1'b1;

    // register read
    always_comb begin
        prdata = '0;
        unique case (paddr[ADDR_W-1:2])
            REG_WINDOW: prdata = DATA_W'(win_reg);
            default:    prdata = '0;
        endcase
    end

    // offsets of the captured request from the next expected position
    assign off  = pos_reg - next_exp_reg;
    assign eoff = seg_end_reg - next_exp_reg;
    assign lim  = (win_reg > CAP_CNT) ? CAP_CNT : win_reg;
    assign in_win = (off[POS_W-1:WIN_W] == '0) && (off[WIN_W-1:0] < lim);
    assign take_byte = carries_reg && in_win && (!end_known_reg || (off < end_dist_reg));
    assign end_ok = eos_reg && (eoff[POS_W-1:WIN_W] == '0) &&
                    (carries_reg ? (eoff[WIN_W-1:0] <= lim) : (eoff[WIN_W-1:0] < lim));

    // ring slot of the byte
    assign slot_sum = {1'b0, head_reg} + {1'b0, off[IDX_W-1:0]};
    assign slot     = (slot_sum >= CAP_SUM) ? IDX_W'(slot_sum - CAP_SUM) : slot_sum[IDX_W-1:0];

    // run walk ends at an empty slot, at the stream end or after a full ring
    assign fin_now   = end_known_reg && (end_dist_reg == POS_W'(cnt_reg));
    assign scan_stop = !valid_reg[ptr_reg] || fin_now || (cnt_reg == CAP_CNT);

    assign ram_we = (state_reg == ST_CALC) && !finished_reg && take_byte && !valid_reg[slot];
    assign ram_re = (state_reg == ST_READ);

    bsr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (CAPACITY)
    ) u_slot_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (slot),
        .wdata (val_reg),
        .re    (ram_re),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    // sequencer: next state and state updates
    always_comb begin
        state_next     = state_reg;
        next_exp_next  = next_exp_reg;
        end_dist_next  = end_dist_reg;
        end_known_next = end_known_reg;
        finished_next  = finished_reg;
        stored_next    = stored_reg;
        head_next      = head_reg;
        valid_next     = valid_reg;
        win_next       = win_reg;
        ptr_next       = ptr_reg;
        cnt_next       = cnt_reg;
        remain_next    = remain_reg;
        fin_res_next   = fin_res_reg;
        pend_res_next  = pend_res_reg;
        out_load       = 1'b0;
        out_has_next   = out_has_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_fin_next   = out_fin_reg;
        out_pend_next  = out_pend_reg;

        // window register write
        if (cfg_we && (paddr[ADDR_W-1:2] == REG_WINDOW)) begin
            win_next = pwdata[WIN_W-1:0];
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                if (finished_reg) begin
                    fin_res_next  = 1'b1;
                    pend_res_next = stored_reg;
                    state_next    = ST_STATUS;
                end else begin
                    // store the byte unless its slot is already filled
                    if (take_byte && !valid_reg[slot]) begin
                        valid_next[slot] = 1'b1;
                        stored_next      = stored_reg + 1'b1;
                    end
                    // latest accepted end marker wins
                    if (end_ok) begin
                        end_known_next = 1'b1;
                        end_dist_next  = eoff;
                    end
                    ptr_next   = head_reg;
                    cnt_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_stop) begin
                    fin_res_next  = fin_now;
                    pend_res_next = fin_now ? '0 : (stored_reg - cnt_reg);
                    stored_next   = fin_now ? '0 : (stored_reg - cnt_reg);
                    finished_next = fin_now;
                    if (fin_now) begin
                        valid_next = '0;
                    end
                    remain_next = cnt_reg;
                    state_next  = (cnt_reg == '0) ? ST_STATUS : ST_READ;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                    ptr_next = (ptr_reg == LAST_IDX) ? '0 : (ptr_reg + 1'b1);
                end
            end
            ST_READ: begin
                // read the head slot and advance past it
                valid_next[head_reg] = 1'b0;
                head_next     = (head_reg == LAST_IDX) ? '0 : (head_reg + 1'b1);
                next_exp_next = next_exp_reg + 1'b1;
                end_dist_next = end_dist_reg - 1'b1;
                remain_next   = remain_reg - 1'b1;
                state_next    = ST_SEND;
            end
            ST_SEND: begin
                if (out_free) begin
                    out_load      = 1'b1;
                    out_has_next  = 1'b1;
                    out_byte_next = ram_rdata;
                    out_last_next = (remain_reg == '0);
                    out_fin_next  = fin_res_reg;
                    out_pend_next = pend_res_reg;
                    state_next    = (remain_reg == '0) ? ST_IDLE : ST_READ;
                end
            end
            ST_STATUS: begin
                if (out_free) begin
                    out_load      = 1'b1;
                    out_has_next  = 1'b0;
                    out_byte_next = '0;
                    out_last_next = 1'b1;
                    out_fin_next  = fin_res_reg;
                    out_pend_next = pend_res_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // output register occupancy
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            next_exp_reg  <= '0;
            end_dist_reg  <= '0;
            end_known_reg <= 1'b0;
            finished_reg  <= 1'b0;
            stored_reg    <= '0;
            head_reg      <= '0;
            valid_reg     <= '0;
            win_reg       <= WINDOW_RST;
            ptr_reg       <= '0;
            cnt_reg       <= '0;
            remain_reg    <= '0;
            fin_res_reg   <= 1'b0;
            pend_res_reg  <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            next_exp_reg  <= next_exp_next;
            end_dist_reg  <= end_dist_next;
            end_known_reg <= end_known_next;
            finished_reg  <= finished_next;
            stored_reg    <= stored_next;
            head_reg      <= head_next;
            valid_reg     <= valid_next;
            win_reg       <= win_next;
            ptr_reg       <= ptr_next;
            cnt_reg       <= cnt_next;
            remain_reg    <= remain_next;
            fin_res_reg   <= fin_res_next;
            pend_res_reg  <= pend_res_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            pos_reg     <= s_byte_position;
            seg_end_reg <= s_byte_position + POS_W'(s_carries_byte);
            val_reg     <= s_byte_value;
            carries_reg <= s_carries_byte;
            eos_reg     <= s_ends_stream;
        end
        out_has_reg  <= out_has_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        out_fin_reg  <= out_fin_next;
        out_pend_reg <= out_pend_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_has_output_byte = out_has_reg;
    assign m_out_byte        = out_byte_reg;
    assign m_last_of_run     = out_last_reg;
    assign m_stream_finished = out_fin_reg;
    assign m_pending_count   = out_pend_reg;

endmodule

// ===== sv/bsr_checker.sv =====
// ----------------------------------------------------------------------------
// bsr_checker
// Port-level checks on the result channel of the byte stream reassembler.
// ----------------------------------------------------------------------------
module bsr_checker
    import bsr_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input logic              m_has_output_byte,
    input logic [BYTE_W-1:0] m_out_byte,
    input logic              m_last_of_run,
    input logic              m_stream_finished,
    input logic [CNT_W-1:0]  m_pending_count
);

    // a stalled result holds its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) &&
            $stable(m_has_output_byte) && $stable(m_last_of_run) &&
            $stable(m_pending_count) && $stable(m_stream_finished))
        else $error("result changed while stalled");

    // a status-only result always closes the run of its request
    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_has_output_byte |-> m_last_of_run && (m_out_byte == '0))
        else $error("status result without last flag or with data");

    // a finished stream has nothing left stored
    a_fin_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_stream_finished |-> (m_pending_count == '0))
        else $error("finished stream reports pending bytes");

    // once a finished result is taken, a result that follows it back to back stays finished
    a_fin_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_stream_finished ##1 m_valid |-> m_stream_finished)
        else $error("finished flag dropped");

endmodule

bind byte_stream_reassembler bsr_checker u_bsr_checker (.*);

// ===== tb/tb_byte_stream_reassembler.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_byte_stream_reassembler
// Self-checking bench for the byte stream reassembler. Out-of-order byte
// requests are driven through a valid/ready channel, and a software copy of
// the reorder ring predicts every in-order byte and status result. The bench
// covers duplicates, window edges, zero and oversize windows, end markers and
// their replacement, finishing, and random reordering with back-pressure.
// ----------------------------------------------------------------------------
module tb_byte_stream_reassembler;
    import bsr_pkg::*;

    localparam logic [ADDR_W-1:0] WINDOW_ADDR = ADDR_W'(4 * int'(REG_WINDOW));
    localparam int unsigned LONG_HOLD = 400;

    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic [BYTE_W-1:0] val;
        logic              carries;
        logic              ends;
    } seg_byte_t;

    typedef struct packed {
        logic              has_byte;
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              fin;
        logic [CNT_W-1:0]  pending;
    } delivery_t;

    logic              aclk;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [POS_W-1:0]  s_byte_position = '0;
    logic [BYTE_W-1:0] s_byte_value = '0;
    logic              s_carries_byte = 1'b0;
    logic              s_ends_stream = 1'b0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic              m_has_output_byte;
    logic [BYTE_W-1:0] m_out_byte;
    logic              m_last_of_run;
    logic              m_stream_finished;
    logic [CNT_W-1:0]  m_pending_count;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    byte_stream_reassembler #(.CAPACITY(CAPACITY_DEF)) DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_byte_position   (s_byte_position),
        .s_byte_value      (s_byte_value),
        .s_carries_byte    (s_carries_byte),
        .s_ends_stream     (s_ends_stream),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_has_output_byte (m_has_output_byte),
        .m_out_byte        (m_out_byte),
        .m_last_of_run     (m_last_of_run),
        .m_stream_finished (m_stream_finished),
        .m_pending_count   (m_pending_count),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    // pending requests and predicted deliveries
    seg_byte_t segment_q [$];
    delivery_t expected_deliveries [$];

    // shadow of the reorder ring
    logic [BYTE_W-1:0] ring_data [CAPACITY_DEF];
    bit                ring_full [CAPACITY_DEF];
    logic [POS_W-1:0]  next_pos = '0;
    logic [POS_W-1:0]  end_pos = '0;
    bit                end_known = 1'b0;
    bit                done = 1'b0;
    int unsigned       head = 0;
    int unsigned       stored = 0;
    logic [WIN_W-1:0]  win_cfg = WINDOW_RST;

    int unsigned errors = 0;
    int unsigned requests_taken = 0;
    int unsigned results_checked = 0;
    int unsigned window_writes = 0;

    // idle control of both sides
    int unsigned gap_left = 0;
    int unsigned calm_tx = 0;
    int unsigned stall_left = 0;
    int unsigned calm_rx = 0;
    int unsigned hold_left = 0;
    bit          hold_go = 1'b0;
    bit          hold_taken = 1'b0;

    // clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // run limit
    initial begin
        #4000000;
        $display("tb: failure");
        $finish;
    end

    function automatic int unsigned draw_wait(inout int unsigned calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            calm = $urandom_range(8, 30);
            return 0;
        end
        return $urandom_range(0, 13);
    endfunction

    // predicts the deliveries caused by one request and updates the ring copy
    task automatic reassemble(input seg_byte_t sb);
        logic [BYTE_W-1:0] run [$];
        logic [POS_W-1:0]  off;
        logic [POS_W-1:0]  seg_end;
        logic [POS_W-1:0]  eoff;
        int unsigned       lim;
        int unsigned       slot;
        bit                ok;
        delivery_t         d;
        if (!done) begin
            lim = (win_cfg > CAPACITY_DEF) ? CAPACITY_DEF : win_cfg;
            off = sb.pos - next_pos;
            // park the byte if it lies in the window and before a known end
            if (sb.carries && off < lim && !(end_known && off >= end_pos - next_pos)) begin
                slot = (head + off) % CAPACITY_DEF;
                if (!ring_full[slot]) begin
                    ring_data[slot] = sb.val;
                    ring_full[slot] = 1'b1;
                    stored++;
                end
            end
            // end marker, taken from the unclamped segment end
            if (sb.ends) begin
                seg_end = sb.pos + POS_W'(sb.carries);
                eoff = seg_end - next_pos;
                ok = sb.carries ? (eoff <= lim) : (eoff < lim);
                if (ok) begin
                    end_known = 1'b1;
                    end_pos = seg_end;
                end
            end
            // drain the contiguous run
            while (run.size() < CAPACITY_DEF && ring_full[head] &&
                   !(end_known && next_pos == end_pos)) begin
                run.push_back(ring_data[head]);
                ring_full[head] = 1'b0;
                head = (head + 1) % CAPACITY_DEF;
                next_pos++;
                if (stored > 0) stored--;
            end
            if (end_known && next_pos == end_pos) begin
                done = 1'b1;
                foreach (ring_full[i]) ring_full[i] = 1'b0;
                stored = 0;
            end
        end
        if (run.size() == 0) begin
            d = '{1'b0, '0, 1'b1, done, CNT_W'(stored)};
            expected_deliveries.push_back(d);
        end else begin
            foreach (run[k]) begin
                d = '{1'b1, run[k], k == run.size() - 1, done, CNT_W'(stored)};
                expected_deliveries.push_back(d);
            end
        end
    endtask

    // request driver
    always @(posedge aclk) begin : drv
        seg_byte_t sb;
        if (!aresetn) begin
            s_valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_valid && s_ready) begin
                reassemble('{s_byte_position, s_byte_value, s_carries_byte, s_ends_stream});
                requests_taken++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (segment_q.size() != 0) begin
                    sb = segment_q[0];
                    segment_q.delete(0);
                    s_byte_position <= sb.pos;
                    s_byte_value <= sb.val;
                    s_carries_byte <= sb.carries;
                    s_ends_stream <= sb.ends;
                    s_valid <= 1'b1;
                    gap_left = draw_wait(calm_tx);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge aclk) begin : mon
        delivery_t got;
        delivery_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got = '{m_has_output_byte, m_out_byte, m_last_of_run, m_stream_finished,
                        m_pending_count};
                results_checked++;
                if (expected_deliveries.size() == 0) begin
                    $display("%0t: unexpected has=%0b byte=%02h last=%0b fin=%0b pend=%0d",
                             $time, got.has_byte, got.data, got.last, got.fin, got.pending);
                    errors++;
                end else begin
                    want = expected_deliveries[0];
                    expected_deliveries.delete(0);
                    if (got !== want) begin
                        $display("%0t: expected has=%0b byte=%02h last=%0b fin=%0b pend=%0d",
                                 $time, want.has_byte, want.data, want.last, want.fin,
                                 want.pending);
                        $display("%0t: actual   has=%0b byte=%02h last=%0b fin=%0b pend=%0d",
                                 $time, got.has_byte, got.data, got.last, got.fin,
                                 got.pending);
                        errors++;
                    end
                end
                stall_left = draw_wait(calm_rx);
            end
            // one long hold-off so the block backs up into its input
            if (hold_go && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic push_seg(input logic [POS_W-1:0] pos, input logic [BYTE_W-1:0] val,
                            input logic carries, input logic ends);
        segment_q.push_back('{pos, val, carries, ends});
    endtask

    task automatic window_read_check(input logic [WIN_W-1:0] want);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= WINDOW_ADDR;
        @(posedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        if (prdata !== DATA_W'(want)) begin
            $display("%0t: window readback expected %0d actual %0d", $time, want, prdata);
            errors++;
        end
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_window(input logic [WIN_W-1:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= WINDOW_ADDR;
        pwdata <= DATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        win_cfg = value;
        window_writes++;
        window_read_check(value);
    endtask

    // wait until every request is taken and every delivery has come back
    task automatic settle();
        do @(negedge aclk);
        while (segment_q.size() != 0 || s_valid || expected_deliveries.size() != 0);
        repeat (8) @(negedge aclk);
    endtask

    // mostly shuffled in-window blocks, one byte sometimes held back a block
    task automatic gen_phase(input int unsigned count, input bit full_first);
        logic [POS_W-1:0] base;
        logic [POS_W-1:0] held_pos;
        logic [POS_W-1:0] new_held;
        logic [POS_W-1:0] tmp;
        logic [POS_W-1:0] blk [$];
        bit               held;
        bit               hold_new;
        int unsigned      lim, made, len, j, k, idx;
        base = next_pos;
        held = 1'b0;
        made = 0;
        lim = (win_cfg > CAPACITY_DEF) ? CAPACITY_DEF : win_cfg;
        while (made < count) begin
            blk.delete();
            if (full_first && made == 0 && lim > 0) begin
                // whole window in reverse: ring fills, then one long run
                for (k = lim; k > 0; k--) push_seg(base + k - 1, $urandom, 1'b1, 1'b0);
                base += lim;
                made += lim;
            end else if (lim == 0 || $urandom_range(0, 99) < 15) begin
                case ($urandom_range(0, 2))
                    0: push_seg($urandom, $urandom, 1'($urandom), 1'b0);
                    1: push_seg(base + 65 + $urandom_range(0, 4000), $urandom,
                                1'($urandom), 1'b1);
                    default: push_seg(base - $urandom_range(1, 40), $urandom, 1'b1, 1'b0);
                endcase
                made++;
            end else begin
                len = $urandom_range(1, (lim >= 2) ? lim / 2 : 1);
                // keep the phase close to its request budget
                if (len > count - made) len = count - made;
                for (k = 0; k < len; k++) blk.push_back(base + k);
                hold_new = (lim >= 2) && ($urandom_range(0, 3) == 0);
                if (hold_new) begin
                    idx = $urandom_range(0, len - 1);
                    new_held = blk[idx];
                    blk.delete(idx);
                end
                if ($urandom_range(0, 3) == 0) blk.push_back(base + $urandom_range(0, len - 1));
                if (held) blk.push_back(held_pos);
                for (k = blk.size(); k > 1; k--) begin
                    j = $urandom_range(0, k - 1);
                    tmp = blk[k - 1];
                    blk[k - 1] = blk[j];
                    blk[j] = tmp;
                end
                foreach (blk[i]) push_seg(blk[i], $urandom, 1'b1, 1'b0);
                made += blk.size();
                held = hold_new;
                held_pos = new_held;
                base += len;
            end
        end
        if (held) push_seg(held_pos, $urandom, 1'b1, 1'b0);
    endtask

    // stimulus sequence
    initial begin : stim
        logic [POS_W-1:0] n;
        int unsigned      k;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        window_read_check(WINDOW_RST);

        // directed: reorder, duplicate, window edges, positions behind
        push_seg(32'd2, 8'hFF, 1'b1, 1'b0);
        push_seg(32'd1, 8'h00, 1'b1, 1'b0);
        push_seg(32'd1, 8'h55, 1'b1, 1'b0);
        push_seg(32'd63, 8'hA5, 1'b1, 1'b0);
        push_seg(32'd64, 8'h5A, 1'b1, 1'b0);
        push_seg(32'hFFFF_FFFF, 8'h81, 1'b1, 1'b0);
        push_seg(32'd0, 8'h3C, 1'b1, 1'b0);
        push_seg(32'd3, 8'h00, 1'b0, 1'b0);
        push_seg(32'd67, 8'h00, 1'b0, 1'b1);
        push_seg(32'hFFFF_FFFF, 8'hC3, 1'b1, 1'b1);
        push_seg(32'h8000_0000, 8'h7E, 1'b1, 1'b0);
        settle();

        // full window with one long receiver hold-off
        set_window(7'd64);
        gen_phase(75, 1'b1);
        hold_go = 1'b1;
        settle();

        // one-byte window
        set_window(7'd1);
        gen_phase(20, 1'b0);
        settle();

        // zero window: nothing is taken, no end marker is heeded
        set_window(7'd0);
        n = next_pos;
        push_seg(n, $urandom, 1'b1, 1'b0);
        push_seg(n, 8'h00, 1'b0, 1'b1);
        push_seg(n, $urandom, 1'b1, 1'b1);
        push_seg(n + 1, $urandom, 1'b1, 1'b0);
        push_seg($urandom, $urandom, 1'($urandom), 1'($urandom));
        push_seg($urandom, $urandom, 1'b1, 1'b0);
        settle();

        // oversize window acts as the full ring
        set_window(7'd127);
        gen_phase(20, 1'b0);
        settle();

        set_window(WIN_W'($urandom_range(2, 63)));
        gen_phase(20, 1'b0);
        settle();

        // directed end handling: replacement, bytes at the end, finishing
        set_window(7'd64);
        n = next_pos;
        push_seg(n + 64, 8'h00, 1'b0, 1'b1);
        push_seg(n + 5, $urandom, 1'b1, 1'b1);
        push_seg(n + 6, $urandom, 1'b1, 1'b0);
        push_seg(n + 10, 8'h00, 1'b0, 1'b1);
        push_seg(n + 9, $urandom, 1'b1, 1'b0);
        push_seg(n + 10, $urandom, 1'b1, 1'b0);
        for (k = 1; k <= 8; k++) begin
            if (k != 5) push_seg(n + k, $urandom, 1'b1, 1'b0);
        end
        push_seg(n, $urandom, 1'b1, 1'b0);
        // after finishing only status comes back
        push_seg(n + 10, $urandom, 1'b1, 1'b0);
        push_seg(n + 20, 8'h00, 1'b0, 1'b1);
        settle();
        repeat (20) @(negedge aclk);

        $display("run covered %0d requests and %0d checked results over %0d window settings",
                 requests_taken, results_checked, window_writes);
        $display("zero/oversize windows, full-ring run, receiver hold-off; end reached: %0s",
                 done ? "yes" : "no");
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
